>>> sv/srba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strided ring buffer allocator package
// Field widths, status codes, reset constants and the structs that carry
// requests to and answers from the shared divider.
// ----------------------------------------------------------------------------
package srba_pkg;

  // Field widths.
  localparam int POS_W    = 25;
  localparam int CNT_W    = 24;
  localparam int STRIDE_W = 11;
  localparam int CTR_W    = 32;
  localparam int PROD_W   = CNT_W + STRIDE_W;

  // Size of the ring after reset.
  localparam int KIB         = 1024;
  localparam int DEFAULT_KIB = 4096;
  localparam logic [POS_W-1:0] BUF_RESET = POS_W'(DEFAULT_KIB * KIB);

  // Default limit on the usable buffer size, as a power of two.
  localparam int SIZE_BITS_DEF = 24;

  // The divider retires two quotient bits per step.
  localparam int DIV_STEPS = (POS_W + 1) / 2;
  localparam int DQ_W      = 2 * DIV_STEPS;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // Request types.
  localparam logic REQ_LOCK   = 1'b0;
  localparam logic REQ_UNLOCK = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_ZERO_COUNT  = 2'd1,
    ST_ZERO_STRIDE = 2'd2,
    ST_OVERSIZE    = 2'd3
  } status_t;

  // Start of a division.
  typedef struct packed {
    logic                start;
    logic [POS_W-1:0]    dividend;
    logic [STRIDE_W-1:0] divisor;
  } div_req_t;

  // Finished division.
  typedef struct packed {
    logic                done;
    logic [POS_W-1:0]    quotient;
    logic [STRIDE_W-1:0] remainder;
  } div_rsp_t;

endpackage

>>> sv/srba_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strided ring buffer allocator channels
// Valid/ready channels for requests, results and the size register write.
// ----------------------------------------------------------------------------

// Lock or unlock request.
interface srba_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [srba_pkg::CNT_W-1:0]    vertex_count;
  logic [srba_pkg::STRIDE_W-1:0] stride;

  modport source (output valid, req_type, vertex_count, stride, input ready);
  modport sink   (input valid, req_type, vertex_count, stride, output ready);
endinterface

// Allocation result.
interface srba_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [srba_pkg::CNT_W-1:0] vertex_offset;
  logic [srba_pkg::POS_W-1:0] byte_offset;
  logic [srba_pkg::POS_W-1:0] byte_length;
  logic                       discard;
  logic [srba_pkg::CTR_W-1:0] discard_count;
  logic [1:0]                 status;

  modport source (output valid, vertex_offset, byte_offset, byte_length, discard,
                  discard_count, status, input ready);
  modport sink   (input valid, vertex_offset, byte_offset, byte_length, discard,
                  discard_count, status, output ready);
endinterface

// Buffer size register write.
interface srba_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [srba_pkg::POS_W-1:0] buffer_bytes;

  modport source (output valid, buffer_bytes, input ready);
  modport sink   (input valid, buffer_bytes, output ready);
endinterface

>>> sv/strided_ring_buffer_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strided ring buffer allocator
// Ring allocator for a dynamic vertex buffer with wrap-and-discard.
//
//   Channel  Dir  Beat contents
//   req      in   req_type, vertex_count, stride
//   rsp      out  vertex_offset, byte_offset, byte_length, discard,
//                 discard_count, status
//   cfg      in   buffer_bytes (always ready)
//
// A lock that passes the checks goes through the product, the checks, then
// two divisions of 13 two-bit steps each on one shared divider, buffer size
// first and byte position second, then a finishing state. Unlocks and
// rejected requests skip the divisions. The request side is ready only when
// the sequencer is idle, so a new beat is taken only once the previous one
// has left the finishing state. A result waits in the output register while
// rsp is stalled; the next request is accepted meanwhile and finishes once
// that register frees.
// Reset is synchronous and clears the position, the wrap counter and the
// size register to 4 MiB.
// ----------------------------------------------------------------------------
module strided_ring_buffer_allocator_top #(
  parameter int SIZE_BITS = srba_pkg::SIZE_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  srba_req_if.sink     req,
  srba_rsp_if.source   rsp,
  srba_cfg_if.sink     cfg
);

  localparam int PW  = srba_pkg::POS_W;
  localparam int NW  = srba_pkg::CNT_W;
  localparam int SW  = srba_pkg::STRIDE_W;
  localparam int CW  = srba_pkg::CTR_W;
  localparam int MW  = srba_pkg::PROD_W;

  // Usable size is limited to 1 << SIZE_BITS.
  localparam bit          CAP_ON = (SIZE_BITS < PW);
  localparam logic [PW-1:0] CAP  = CAP_ON ? PW'(64'd1 << SIZE_BITS) : '1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MUL    = 6'b000010,
    S_CHECK  = 6'b000100,
    S_DCAP   = 6'b001000,
    S_DPOS   = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state, state_next;

  // Architectural state.
  logic [PW-1:0] buffer_bytes;
  logic [PW-1:0] position;
  logic [CW-1:0] wrap_ctr;

  // Latched request and intermediate values.
  logic                  req_type_r;
  logic [NW-1:0]         count_r;
  logic [SW-1:0]         stride_r;
  logic [MW-1:0]         prod;
  srba_pkg::status_t     status_r;
  logic [PW-1:0]         vcap;
  logic [PW:0]           vpos;
  logic [SW-1:0]         prem;

  // Output register.
  logic          out_valid;
  logic [NW-1:0] out_voff;
  logic [PW-1:0] out_boff;
  logic [PW-1:0] out_blen;
  logic          out_disc;
  logic [CW-1:0] out_dcnt;
  logic [1:0]    out_status;

  srba_pkg::div_req_t div_req;
  srba_pkg::div_rsp_t div_rsp;

  logic              [PW-1:0] size;
  srba_pkg::status_t          status_chk;
  logic                       lock_go;
  logic                       fin_go;
  logic              [PW:0]   unl_sum;
  logic              [PW-1:0] unl_pos;
  logic              [PW:0]   need;
  logic                       wrap;
  logic              [PW-1:0] lock_pos;

  // Effective ring size.
  always_comb begin
    size = (CAP_ON && (buffer_bytes > CAP)) ? CAP : buffer_bytes;
  end

  // Request checks in priority order.
  always_comb begin
    priority if (count_r == '0) begin
      status_chk = srba_pkg::ST_ZERO_COUNT;
    end else if (stride_r == '0) begin
      status_chk = srba_pkg::ST_ZERO_STRIDE;
    end else if (prod > MW'(size)) begin
      status_chk = srba_pkg::ST_OVERSIZE;
    end else begin
      status_chk = srba_pkg::ST_OK;
    end
  end

  assign lock_go = (status_chk == srba_pkg::ST_OK) && (req_type_r == srba_pkg::REQ_LOCK);
  assign fin_go  = (state == S_FINISH) && (!out_valid || rsp.ready);

  // Divider requests: buffer size first, then the byte position.
  always_comb begin
    div_req.start    = ((state == S_CHECK) && lock_go) || ((state == S_DCAP) && div_rsp.done);
    div_req.dividend = (state == S_CHECK) ? size : position;
    div_req.divisor  = stride_r;
  end

  srba_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Unlock advance, saturating at the buffer size.
  always_comb begin
    unl_sum = {1'b0, position} + {1'b0, prod[PW-1:0]};
    unl_pos = (unl_sum < {1'b0, size}) ? unl_sum[PW-1:0] : size;
  end

  // Lock fit test; the next vertex boundary is position - remainder + stride.
  always_comb begin
    need     = (PW+1)'(count_r) + vpos;
    wrap     = (need >= {1'b0, vcap});
    lock_pos = (position - PW'(prem)) + PW'(stride_r);
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_MUL;
      end
      S_MUL: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = lock_go ? S_DCAP : S_FINISH;
      end
      S_DCAP: begin
        if (div_rsp.done) state_next = S_DPOS;
      end
      S_DPOS: begin
        if (div_rsp.done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (fin_go) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  // Size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_bytes <= srba_pkg::BUF_RESET;
    end else if (cfg.valid) begin
      buffer_bytes <= cfg.buffer_bytes;
    end
  end

  // Request capture, product and division results.
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && req.valid) begin
      req_type_r <= req.req_type;
      count_r    <= req.vertex_count;
      stride_r   <= req.stride;
    end
    if (state == S_MUL) begin
      prod <= MW'(count_r) * MW'(stride_r);
    end
    if (state == S_CHECK) begin
      status_r <= status_chk;
    end
    if ((state == S_DCAP) && div_rsp.done) begin
      vcap <= div_rsp.quotient;
    end
    if ((state == S_DPOS) && div_rsp.done) begin
      vpos <= {1'b0, div_rsp.quotient} + (PW+1)'(1);
      prem <= div_rsp.remainder;
    end
  end

  // State update and result formation.
  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      wrap_ctr  <= '0;
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid  <= 1'b1;
      out_status <= status_r;
      if (status_r != srba_pkg::ST_OK) begin
        // A rejected request leaves the state alone and carries no region.
        out_voff <= '0;
        out_boff <= '0;
        out_blen <= '0;
        out_disc <= 1'b0;
        out_dcnt <= wrap_ctr;
      end else if (req_type_r == srba_pkg::REQ_UNLOCK) begin
        position <= unl_pos;
        out_voff <= '0;
        out_boff <= unl_pos;
        out_blen <= prod[PW-1:0];
        out_disc <= 1'b0;
        out_dcnt <= wrap_ctr;
      end else if (wrap) begin
        position <= '0;
        wrap_ctr <= wrap_ctr + CW'(1);
        out_voff <= '0;
        out_boff <= '0;
        out_blen <= prod[PW-1:0];
        out_disc <= 1'b1;
        out_dcnt <= wrap_ctr + CW'(1);
      end else begin
        position <= lock_pos;
        out_voff <= vpos[NW-1:0];
        out_boff <= lock_pos;
        out_blen <= prod[PW-1:0];
        out_disc <= 1'b0;
        out_dcnt <= wrap_ctr;
      end
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.vertex_offset = out_voff;
  assign rsp.byte_offset   = out_boff;
  assign rsp.byte_length   = out_blen;
  assign rsp.discard       = out_disc;
  assign rsp.discard_count = out_dcnt;
  assign rsp.status        = out_status;

  // A wrapped lock is always a good lock that restarts at byte zero.
  a_discard_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.discard |-> (rsp.status == srba_pkg::ST_OK) && (rsp.byte_offset == '0))
    else $error("discard on a failed or misplaced result");

  // A rejected request carries no region.
  a_error_empty: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != srba_pkg::ST_OK) |->
      (rsp.byte_length == '0) && (rsp.byte_offset == '0) && !rsp.discard)
    else $error("error result carries a region");

  // The divider only finishes while the sequencer waits on it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DCAP) || (state == S_DPOS))
    else $error("divider finished outside a division wait");

  // A wrap bumps the counter by exactly one.
  a_wrap_count: assert property (@(posedge clk) disable iff (rst)
    fin_go && (status_r == srba_pkg::ST_OK) && (req_type_r == srba_pkg::REQ_LOCK) && wrap
      |=> wrap_ctr == $past(wrap_ctr) + CW'(1))
    else $error("wrap counter did not advance on discard");

endmodule

>>> sv/srba_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strided ring buffer allocator divider
// Restoring divider of a byte count by a stride, two quotient bits per
// cycle. A start pulse loads the operands; done pulses once with the result.
// ----------------------------------------------------------------------------
module srba_div (
  input  logic               clk,
  input  logic               rst,
  input  srba_pkg::div_req_t req,
  output srba_pkg::div_rsp_t rsp
);

  localparam int PW = srba_pkg::POS_W;
  localparam int SW = srba_pkg::STRIDE_W;
  localparam int QW = srba_pkg::DQ_W;
  localparam int CW = srba_pkg::DCNT_W;

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [QW-1:0] dq;
  logic [SW-1:0] rem;
  logic [SW-1:0] dvs;

  logic [SW:0]   t1, t2, r1, r2, d_ext;
  logic          ge1, ge2;
  logic [QW-1:0] dq_next;

  // Two restoring steps: shift in a dividend bit, subtract when it fits.
  always_comb begin
    d_ext   = {1'b0, dvs};
    t1      = {rem, dq[QW-1]};
    ge1     = (t1 >= d_ext);
    r1      = ge1 ? (t1 - d_ext) : t1;
    t2      = {r1[SW-1:0], dq[QW-2]};
    ge2     = (t2 >= d_ext);
    r2      = ge2 ? (t2 - d_ext) : t2;
    dq_next = {dq[QW-3:0], ge1, ge2};
  end

  // Step counter and control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(srba_pkg::DIV_STEPS - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(srba_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: dividend bits shift out at the top while quotient bits enter.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dq  <= {{(QW-PW){1'b0}}, req.dividend};
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      dq  <= dq_next;
      rem <= r2[SW-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = dq[PW-1:0];
  assign rsp.remainder = rem;

endmodule

>>> sim/tb_strided_ring_buffer_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strided ring buffer allocator testbench
// Drives lock and unlock beats through the request channel with random gaps
// and stalls the result channel at random. An in-bench allocator model
// predicts every result from the accepted beats. The buffer size register is
// rewritten between phases, with the extremes among the settings.
// ----------------------------------------------------------------------------
module tb_strided_ring_buffer_allocator_top;

  // One request beat as the bench sees it.
  typedef struct packed {
    logic                          kind;
    logic [srba_pkg::CNT_W-1:0]    count;
    logic [srba_pkg::STRIDE_W-1:0] stride;
  } alloc_req_t;

  // One predicted result beat.
  typedef struct packed {
    logic [srba_pkg::CNT_W-1:0] voff;
    logic [srba_pkg::POS_W-1:0] boff;
    logic [srba_pkg::POS_W-1:0] blen;
    logic                       disc;
    logic [srba_pkg::CTR_W-1:0] dcnt;
    srba_pkg::status_t          st;
  } alloc_rsp_t;

  logic clk;
  logic rst;

  srba_req_if req_ch ();
  srba_rsp_if rsp_ch ();
  srba_cfg_if cfg_ch ();

  strided_ring_buffer_allocator_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Allocator model state and the size register copy.
  logic [srba_pkg::POS_W-1:0] ring_pos  = '0;
  logic [srba_pkg::CTR_W-1:0] wrap_ctr  = '0;
  logic [srba_pkg::POS_W-1:0] ring_size = srba_pkg::BUF_RESET;

  alloc_req_t requests_q[$];
  alloc_rsp_t grants_due[$];
  int         items_owed = 0;
  int         fails      = 0;
  bit         req_fired  = 1'b0;
  bit         quiet      = 1'b0;
  int         send_gap   = 0;
  int         rsp_stall  = 0;

  // Clock with an 8 ns period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Usable ring size: the register limited to the power-of-two cap.
  function automatic logic [63:0] usable_size();
    logic [63:0] cap;
    cap = 64'd1 << srba_pkg::SIZE_BITS_DEF;
    return (64'(ring_size) < cap) ? 64'(ring_size) : cap;
  endfunction

  // Apply one request to the model state and return the result it gives.
  function automatic alloc_rsp_t allocate(alloc_req_t rq);
    logic [63:0] size, bytes, vcap, vpos, np, stw;
    alloc_rsp_t r;
    r     = '0;
    r.st  = srba_pkg::ST_OK;
    size  = usable_size();
    stw   = 64'(rq.stride);
    bytes = 64'(rq.count) * stw;
    if (rq.count == '0) begin
      r.st = srba_pkg::ST_ZERO_COUNT;
    end else if (rq.stride == '0) begin
      r.st = srba_pkg::ST_ZERO_STRIDE;
    end else if (bytes > size) begin
      r.st = srba_pkg::ST_OVERSIZE;
    end
    if (r.st == srba_pkg::ST_OK) begin
      r.blen = bytes[srba_pkg::POS_W-1:0];
      if (rq.kind == srba_pkg::REQ_LOCK) begin
        // The position is rounded down to a vertex and one vertex is skipped.
        vcap = size / stw;
        vpos = 64'(ring_pos) / stw + 64'd1;
        if (64'(rq.count) + vpos >= vcap) begin
          ring_pos = '0;
          wrap_ctr = wrap_ctr + 1'b1;
          r.disc   = 1'b1;
        end else begin
          ring_pos = srba_pkg::POS_W'(vpos * stw);
          r.voff   = vpos[srba_pkg::CNT_W-1:0];
        end
      end else begin
        np       = 64'(ring_pos) + bytes;
        ring_pos = (np < size) ? np[srba_pkg::POS_W-1:0] : size[srba_pkg::POS_W-1:0];
      end
      r.boff = ring_pos;
    end
    r.dcnt = wrap_ctr;
    return r;
  endfunction

  // Idle length: mostly none, sometimes short, rarely long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 48);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Request acceptance: predict the result of each accepted beat.
  always @(posedge clk) begin
    req_fired = !rst && req_ch.valid && req_ch.ready;
    if (req_fired) begin
      grants_due.push_back(allocate('{req_ch.req_type, req_ch.vertex_count, req_ch.stride}));
      items_owed--;
    end
  end

  // Request driver: holds a beat until it is taken, then idles or sends the next.
  always @(negedge clk) begin
    alloc_req_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fired) begin
      if (send_gap > 0) begin
        send_gap--;
        req_ch.valid <= 1'b0;
      end else if (requests_q.size() > 0) begin
        nxt = requests_q.pop_front();
        req_ch.req_type     <= nxt.kind;
        req_ch.vertex_count <= nxt.count;
        req_ch.stride       <= nxt.stride;
        req_ch.valid        <= 1'b1;
        send_gap = quiet ? 0 : gap_len();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result ready: random stalls of random length.
  always @(negedge clk) begin
    int n;
    if (rsp_stall > 0) begin
      rsp_stall--;
      rsp_ch.ready <= 1'b0;
    end else begin
      n = quiet ? 0 : gap_len();
      if (n > 0 && $urandom_range(0, 3) == 0) begin
        rsp_stall = n - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Result monitor: compare each beat with the oldest prediction.
  always @(posedge clk) begin
    alloc_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (grants_due.size() == 0) begin
        fails++;
        $display("%0t ns: unexpected result, expected none, actual byte_offset %0d status %0d",
                 $time, rsp_ch.byte_offset, rsp_ch.status);
      end else begin
        want = grants_due.pop_front();
        check_field("vertex_offset", 32'(want.voff), 32'(rsp_ch.vertex_offset));
        check_field("byte_offset", 32'(want.boff), 32'(rsp_ch.byte_offset));
        check_field("byte_length", 32'(want.blen), 32'(rsp_ch.byte_length));
        check_field("discard", 32'(want.disc), 32'(rsp_ch.discard));
        check_field("discard_count", want.dcnt, rsp_ch.discard_count);
        check_field("status", 32'(want.st), 32'(rsp_ch.status));
      end
    end
  end

  task automatic send(logic kind, int unsigned count, int unsigned stride);
    requests_q.push_back('{kind, srba_pkg::CNT_W'(count), srba_pkg::STRIDE_W'(stride)});
    items_owed++;
  endtask

  // Wait until every queued beat is taken and every result has come back.
  task automatic settle();
    while (items_owed != 0 || grants_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Write the size register; called only while the block is idle.
  task automatic write_size(int unsigned bytes);
    cfg_ch.buffer_bytes <= srba_pkg::POS_W'(bytes);
    cfg_ch.valid        <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    ring_size = srba_pkg::POS_W'(bytes);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Random traffic: mostly lock and unlock pairs that fit, some malformed beats.
  task automatic queue_traffic(int n);
    int unsigned sz, st, vmax, cnt;
    int sent, r;
    sz   = int'(usable_size());
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send($urandom_range(0, 1), 0, $urandom_range(0, 1024));
        sent++;
      end else if (r < 8) begin
        send($urandom_range(0, 1), $urandom_range(1, 16777215), 0);
        sent++;
      end else if (r < 14) begin
        send($urandom_range(0, 1), $urandom() & 32'hFFFFFF, $urandom_range(0, 1024));
        sent++;
      end else begin
        r = $urandom_range(0, 9);
        if (r < 3) st = $urandom_range(1, 4);
        else if (r == 3) st = 1024;
        else st = $urandom_range(1, 1024);
        vmax = sz / st;
        r = $urandom_range(0, 9);
        if (vmax == 0) cnt = 1;
        else if (r < 6) cnt = $urandom_range(1, (vmax < 32) ? vmax : 32);
        else if (r < 9) cnt = $urandom_range(1, (vmax < 4) ? 1 : vmax / 4);
        else cnt = $urandom_range(1, vmax);
        send(srba_pkg::REQ_LOCK, cnt, st);
        sent++;
        if ($urandom_range(0, 9) < 7) begin
          send(srba_pkg::REQ_UNLOCK, $urandom_range(1, cnt), st);
          sent++;
        end
      end
    end
  endtask

  // Stimulus and end of run.
  initial begin
    int unsigned sizes[8];
    int          counts[8];
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = srba_pkg::REQ_LOCK;
    req_ch.vertex_count = '0;
    req_ch.stride       = '0;
    rsp_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.buffer_bytes = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset size of 4 MiB.
    send(srba_pkg::REQ_LOCK, 1, 1);              // one vertex is always skipped
    send(srba_pkg::REQ_UNLOCK, 1, 1);
    send(srba_pkg::REQ_LOCK, 0, 0);              // zero count wins over zero stride
    send(srba_pkg::REQ_LOCK, 5, 0);
    send(srba_pkg::REQ_UNLOCK, 0, 7);
    send(srba_pkg::REQ_UNLOCK, 3, 0);
    send(srba_pkg::REQ_LOCK, 16777215, 1024);    // oversize with the widest count
    send(srba_pkg::REQ_UNLOCK, 4097, 1024);      // one vertex over the buffer
    send(srba_pkg::REQ_LOCK, 4096, 1024);        // exactly the buffer: wraps
    send(srba_pkg::REQ_LOCK, 4094, 1024);        // fits just below the capacity
    send(srba_pkg::REQ_LOCK, 4095, 1024);        // passes the capacity: wraps
    send(srba_pkg::REQ_UNLOCK, 4096, 1024);      // lands on the end of the buffer
    send(srba_pkg::REQ_UNLOCK, 1, 1);            // saturates at the buffer size
    send(srba_pkg::REQ_LOCK, 1, 3);              // position at the end: wraps
    send(srba_pkg::REQ_LOCK, 2, 1000);
    send(srba_pkg::REQ_UNLOCK, 7, 1000);
    send(srba_pkg::REQ_LOCK, 3, 1000);           // position already on a vertex: one is skipped
    settle();

    // Largest buffer: push the vertex offset near its top, then shrink.
    write_size(16777216);
    send(srba_pkg::REQ_UNLOCK, 16777215, 1);
    send(srba_pkg::REQ_LOCK, 1, 1);
    send(srba_pkg::REQ_UNLOCK, 16777000, 1);
    send(srba_pkg::REQ_LOCK, 1, 1);
    settle();
    write_size(4096);
    send(srba_pkg::REQ_LOCK, 1, 1);              // position beyond the buffer: wraps
    settle();
    write_size(16777216);
    send(srba_pkg::REQ_UNLOCK, 16777215, 1);
    settle();
    write_size(4096);
    send(srba_pkg::REQ_UNLOCK, 1, 4);            // position beyond the buffer: saturates
    settle();

    // Random phases over several buffer sizes.
    sizes  = '{16777216, 1, 65536, 1000, $urandom_range(1, 16777216), 4096,
               $urandom_range(1024, 262144), 4194304};
    counts = '{190, 60, 190, 180, 190, 190, 190, 190};
    for (int p = 0; p < 8; p++) begin
      quiet = (p == 3 || p == 6);
      write_size(sizes[p]);
      queue_traffic(counts[p]);
      settle();
    end
    quiet = 1'b0;

    repeat (40) @(negedge clk);
    if (fails == 0 && grants_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #(8_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> strided_ring_buffer_allocator_top.f
sv/srba_pkg.sv
sv/srba_ifs.sv
sv/srba_div.sv
sv/strided_ring_buffer_allocator_top.sv
sim/tb_strided_ring_buffer_allocator_top.sv
